// File: src/clb_pkg.sv
package clb_pkg;

    localparam int COORD_W       = 32;
    localparam int INV_FRAC_BITS = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CPA_W         = 5;
    localparam int OBJ_W         = 16;
    localparam int CELL_OUT_W    = 4;
    localparam int S_TDATA_W     = 96;
    localparam int M_TDATA_W     = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_SIZE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_AXIS = 3'd4;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic             occupied;
        logic [OBJ_W-1:0] head;
    } clb_entry_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } clb_mem_ctrl_t;

endpackage

// File: src/clb_axis.sv
module clb_axis
    import clb_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16,
    parameter int AXIS_W          = 4
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [COORD_W-1:0] pos,
    input  logic [COORD_W-1:0] origin,
    input  logic [COORD_W-1:0] inv_cell_size,
    input  logic [AXIS_W-1:0]  lim,
    output logic [AXIS_W-1:0]  cell_idx
);

    localparam int SHIFT = COORD_FRAC_BITS + INV_FRAC_BITS;

    logic [COORD_W:0]     diff_reg;
    logic [COORD_W:0]     diff_next;
    logic [2*COORD_W-1:0] prod_reg;
    logic [2*COORD_W-1:0] prod_next;
    logic                 nonpos_reg;
    logic                 nonpos_next;
    logic [2*COORD_W-1:0] quot;
    logic [AXIS_W-1:0]    cell_reg;
    logic [AXIS_W-1:0]    cell_next;

    // The difference of two signed 32-bit values never exceeds 2^32 - 1,
    // so a positive difference fits in the low 32 bits.
    assign diff_next   = {pos[COORD_W-1], pos} - {origin[COORD_W-1], origin};
    assign nonpos_next = diff_reg[COORD_W] || (diff_reg == '0);
    assign prod_next   = {{COORD_W{1'b0}}, diff_reg[COORD_W-1:0]} *
                         {{COORD_W{1'b0}}, inv_cell_size};
    assign quot        = prod_reg >> SHIFT;

    always_comb begin
        if (nonpos_reg) begin
            cell_next = '0;
        end else if (quot >= (2*COORD_W)'(lim)) begin
            cell_next = lim;
        end else begin
            cell_next = quot[AXIS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            diff_reg   <= diff_next;
            prod_reg   <= prod_next;
            nonpos_reg <= nonpos_next;
            cell_reg   <= cell_next;
        end
    end

    assign cell_idx = cell_reg;

endmodule

// File: src/clb_table.sv
module clb_table
    import clb_pkg::*;
#(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  clb_mem_ctrl_t     ctrl,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic [ADDR_W-1:0] wr_addr,
    input  clb_entry_t        wr_entry,
    output clb_entry_t        rd_entry
);

    clb_entry_t        mem [DEPTH];
    clb_entry_t        mem_q_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic              lw_vld_reg;
    logic [ADDR_W-1:0] lw_addr_reg;
    clb_entry_t        lw_entry_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        if (ctrl.rd_en) begin
            mem_q_reg   <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // The most recent write is kept so that a read issued at the same edge
    // still sees it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_vld_reg <= 1'b0;
        end else if (ctrl.wr_en) begin
            lw_vld_reg <= 1'b1;
        end
        if (ctrl.wr_en) begin
            lw_addr_reg  <= wr_addr;
            lw_entry_reg <= wr_entry;
        end
    end

    assign rd_entry = (lw_vld_reg && (lw_addr_reg == rd_addr_reg)) ? lw_entry_reg : mem_q_reg;

endmodule

// File: src/cell_list_binner_top.sv
// Channel   Direction  Ports                          Carries
// s_        in         s_tvalid/s_tready/s_tdata/s_tuser  point or clear request
// m_        out        m_tvalid/m_tready/m_tdata      cell entry for each insert up to MAX_OBJECTS
// cfg_      in         cfg_valid/cfg_ready/cfg_index/cfg_data  register write
//
// An insert is taken every cycle s_tready is high and goes through stages a, b, c, e and the output.
// The rate is set by the head table read-modify-write, which forwards the last write.
// After reset all MAX_CELLS_PER_AXIS^3 table rows (4096 by default) are swept before s_tready rises.
// A clear request drains the pipeline and then sweeps every row of the table again.
// A stall on m_tready freezes the whole pipeline and drops s_tready in the same cycle.
module cell_list_binner_top
    import clb_pkg::*;
#(
    parameter int MAX_CELLS_PER_AXIS = 16,
    parameter int MAX_OBJECTS        = 65536,
    parameter int COORD_FRAC_BITS    = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // pos_x, pos_y, pos_z
    input  logic                 s_tuser,   // command
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // object_index, cell_x, cell_y, cell_z, prev_object, prev_valid, zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data
);

    localparam int AXIS_W = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1;
    localparam int DEPTH  = MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(MAX_OBJECTS + 1);
    localparam logic [ADDR_W-1:0] MUL_X    = ADDR_W'(MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS);
    localparam logic [ADDR_W-1:0] MUL_Y    = ADDR_W'(MAX_CELLS_PER_AXIS);
    localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        ST_SWEEP = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } clb_state_t;

    clb_state_t state_reg, state_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [COORD_W-1:0] origin_x_reg, origin_y_reg, origin_z_reg, inv_reg;
    logic [CPA_W-1:0]   cpa_reg;

    logic vld_a_reg, vld_b_reg, vld_c_reg, vld_e_reg;
    logic [ADDR_W-1:0] addr_e_reg;
    logic [AXIS_W-1:0] cx_e_reg, cy_e_reg, cz_e_reg;

    logic                  m_tvalid_reg;
    logic [OBJ_W-1:0]      obj_out_reg, prev_out_reg;
    logic [CELL_OUT_W-1:0] cx_out_reg, cy_out_reg, cz_out_reg;
    logic                  pv_out_reg;

    logic              en, accept, room, take;
    logic [6:0]        cells_used;
    logic [AXIS_W-1:0] lim;
    logic [AXIS_W-1:0] cx_c, cy_c, cz_c;
    logic [ADDR_W-1:0] addr_c;
    logic [31:0]       cnt_wide;
    logic [7:0]        cx_wide, cy_wide, cz_wide;
    clb_mem_ctrl_t     mem_ctrl;
    logic [ADDR_W-1:0] wr_addr;
    clb_entry_t        wr_entry, rd_entry;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            inv_reg      <= 32'd65536;
            cpa_reg      <= 5'd16;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ORIGIN_X:       origin_x_reg <= cfg_data;
                CFG_ORIGIN_Y:       origin_y_reg <= cfg_data;
                CFG_ORIGIN_Z:       origin_z_reg <= cfg_data;
                CFG_INV_CELL_SIZE:  inv_reg      <= cfg_data;
                CFG_CELLS_PER_AXIS: cpa_reg      <= cfg_data[CPA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cells_used = (cpa_reg == '0) ? 7'd1 : 7'(cpa_reg);
        if (cells_used > 7'(MAX_CELLS_PER_AXIS)) begin
            cells_used = 7'(MAX_CELLS_PER_AXIS);
        end
    end
    assign lim = AXIS_W'(cells_used - 7'd1);

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en && (state_reg == ST_RUN);
    assign accept   = s_tvalid && s_tready;

    clb_axis #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .AXIS_W(AXIS_W)) u_axis_x (
        .aclk(aclk), .en(en), .pos(s_tdata[31:0]), .origin(origin_x_reg),
        .inv_cell_size(inv_reg), .lim(lim), .cell_idx(cx_c)
    );
    clb_axis #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .AXIS_W(AXIS_W)) u_axis_y (
        .aclk(aclk), .en(en), .pos(s_tdata[63:32]), .origin(origin_y_reg),
        .inv_cell_size(inv_reg), .lim(lim), .cell_idx(cy_c)
    );
    clb_axis #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .AXIS_W(AXIS_W)) u_axis_z (
        .aclk(aclk), .en(en), .pos(s_tdata[95:64]), .origin(origin_z_reg),
        .inv_cell_size(inv_reg), .lim(lim), .cell_idx(cz_c)
    );

    assign addr_c = ADDR_W'(cx_c) * MUL_X + ADDR_W'(cy_c) * MUL_Y + ADDR_W'(cz_c);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_e_reg <= 1'b0;
        end else if (en) begin
            vld_a_reg <= accept && (s_tuser == CMD_INSERT);
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
            vld_e_reg <= vld_c_reg;
        end
        if (en) begin
            addr_e_reg <= addr_c;
            cx_e_reg   <= cx_c;
            cy_e_reg   <= cy_c;
            cz_e_reg   <= cz_c;
        end
    end

    assign room     = cnt_reg < CNT_W'(MAX_OBJECTS);
    assign take     = en && vld_e_reg && room;
    assign cnt_wide = 32'(cnt_reg);
    assign cx_wide  = 8'(cx_e_reg);
    assign cy_wide  = 8'(cy_e_reg);
    assign cz_wide  = 8'(cz_e_reg);

    always_comb begin
        mem_ctrl.rd_en = en;
        mem_ctrl.wr_en = (state_reg == ST_SWEEP) || take;
        if (state_reg == ST_SWEEP) begin
            wr_addr           = sweep_reg;
            wr_entry.occupied = 1'b0;
            wr_entry.head     = '0;
        end else begin
            wr_addr           = addr_e_reg;
            wr_entry.occupied = 1'b1;
            wr_entry.head     = cnt_wide[OBJ_W-1:0];
        end
    end

    clb_table #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_table (
        .aclk(aclk), .aresetn(aresetn), .ctrl(mem_ctrl), .rd_addr(addr_c),
        .wr_addr(wr_addr), .wr_entry(wr_entry), .rd_entry(rd_entry)
    );

    always_comb begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_SWEEP: begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_ROW) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (take) begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (accept && (s_tuser == CMD_CLEAR)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (take) begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (!vld_a_reg && !vld_b_reg && !vld_c_reg && !vld_e_reg) begin
                    state_next = ST_SWEEP;
                    sweep_next = '0;
                    cnt_next   = '0;
                end
            end
            default: begin
                state_next = ST_SWEEP;
                sweep_next = '0;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SWEEP;
            sweep_reg <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vld_e_reg && room;
        end
        if (en) begin
            obj_out_reg  <= cnt_wide[OBJ_W-1:0];
            cx_out_reg   <= cx_wide[CELL_OUT_W-1:0];
            cy_out_reg   <= cy_wide[CELL_OUT_W-1:0];
            cz_out_reg   <= cz_wide[CELL_OUT_W-1:0];
            prev_out_reg <= rd_entry.occupied ? rd_entry.head : '0;
            pv_out_reg   <= rd_entry.occupied;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, pv_out_reg, prev_out_reg, cz_out_reg, cy_out_reg, cx_out_reg,
                       obj_out_reg};

endmodule
